>>> src/tafs_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the tile animation frame stepper.
// No dependencies; every other file imports this package.
package tafs_pkg;

  // Parameter defaults
  localparam int MAX_TILES_DEF     = 16;
  localparam int MAX_FRAMES_DEF    = 16;
  localparam int ADVANCE_LIMIT_DEF = 64;

  // Tiles walked per tick never exceed what the tile field can name
  localparam int WALK_CAP   = 16;
  localparam int TILE_CNT_W = 5;

  // Field widths
  localparam int FUNC_W     = 2;
  localparam int INDEX_W    = 4;
  localparam int TILE_NUM_W = 12;
  localparam int DUR_W      = 16;
  localparam int TOTAL_W    = 5;
  localparam int ELAPSED_W  = 16;
  localparam int TIME_W     = 20;
  localparam int COORD_W    = 20;
  localparam int OFFSET_W   = 28;
  localparam int OUT_TILE_W = 4;

  // Stream widths
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 72;

  // Configuration registers
  localparam int ROW_W      = 13;
  localparam int DIM_W      = 9;
  localparam int PIX_W      = 17;
  localparam int ACT_W      = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  localparam logic [ROW_W-1:0] TILES_PER_ROW_RST = 13'd1;
  localparam logic [DIM_W-1:0] TILE_WIDTH_RST    = 9'd16;
  localparam logic [DIM_W-1:0] TILE_HEIGHT_RST   = 9'd16;
  localparam logic [PIX_W-1:0] TILE_PIXELS_RST   = 17'd256;
  localparam logic [ACT_W-1:0] ACTIVE_TILES_RST  = 5'd0;

  localparam logic [CFG_IDX_W-1:0] REG_TILES_PER_ROW = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_WIDTH    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_HEIGHT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_PIXELS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_TILES  = 3'd4;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_COUNT = 2'd1,
    FUNC_TICK  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_CMP,
    ST_DIV,
    ST_MUL,
    ST_EMIT,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic [DUR_W-1:0]      dur;
    logic [TILE_NUM_W-1:0] dst;
    logic [TILE_NUM_W-1:0] src;
  } frame_entry_t;

  // Controller to datapath
  typedef struct packed {
    logic wr_entry;
    logic set_count;
    logic tick_start;
    logic next_tile;
    logic tile_begin;
    logic advance;
    logic tile_close;
    logic div_start;
    logic mul_cap;
    logic pend_load;
    logic out_push;
    logic out_last;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic tile_end;
    logic cnt_zero;
    logic can_adv;
    logic changed;
    logic div_busy;
    logic pend_valid;
    logic out_free;
  } status_t;

endpackage

>>> src/tafs_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, for the slot row/column split.
// Depends on tafs_pkg for the operand widths.
module tafs_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [tafs_pkg::TILE_NUM_W-1:0] dividend,
  input  logic [tafs_pkg::ROW_W-1:0]      divisor,
  output logic                            busy,
  output logic [tafs_pkg::TILE_NUM_W-1:0] quot,
  output logic [tafs_pkg::TILE_NUM_W-1:0] rem
);
  import tafs_pkg::*;

  localparam int STEPS = TILE_NUM_W;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic                  busy_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [TILE_NUM_W-1:0] rem_r;
  logic [TILE_NUM_W-1:0] quo_r;
  logic [ROW_W-1:0]      trial;
  logic [ROW_W-1:0]      diff;
  logic                  ge;

  // Partial remainder never reaches 2^12, so the trial fits the divisor width
  always_comb begin
    trial = {rem_r, quo_r[TILE_NUM_W-1]};
    ge    = (trial >= divisor);
    diff  = trial - divisor;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(STEPS);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
    end else if (busy_r) begin
      rem_r <= ge ? diff[TILE_NUM_W-1:0] : trial[TILE_NUM_W-1:0];
      quo_r <= {quo_r[TILE_NUM_W-2:0], ge};
    end
  end

  assign busy = busy_r;
  assign quot = quo_r;
  assign rem  = rem_r;

endmodule

>>> src/tafs_datapath.sv
`timescale 1ns / 1ps
// Datapath: configuration registers, frame store, per-tile state, frame
// stepping, divider, products and the pending and output result registers.
// Depends on tafs_pkg and tafs_div.
module tafs_datapath #(
  parameter int MAX_TILES     = tafs_pkg::MAX_TILES_DEF,
  parameter int MAX_FRAMES    = tafs_pkg::MAX_FRAMES_DEF,
  parameter int ADVANCE_LIMIT = tafs_pkg::ADVANCE_LIMIT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr,
  input  logic [tafs_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [tafs_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic [tafs_pkg::INDEX_W-1:0]    anim_index,
  input  logic [tafs_pkg::INDEX_W-1:0]    frame_index,
  input  logic [tafs_pkg::TILE_NUM_W-1:0] src_tile,
  input  logic [tafs_pkg::TILE_NUM_W-1:0] dst_tile,
  input  logic [tafs_pkg::DUR_W-1:0]      frame_time,
  input  logic [tafs_pkg::TOTAL_W-1:0]    frame_total,
  input  logic [tafs_pkg::ELAPSED_W-1:0]  elapsed,
  input  tafs_pkg::cmd_t                  cmd,
  output tafs_pkg::status_t               status,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [tafs_pkg::OUT_TILE_W-1:0] out_tile,
  output logic [tafs_pkg::COORD_W-1:0]    dest_x,
  output logic [tafs_pkg::COORD_W-1:0]    dest_y,
  output logic [tafs_pkg::OFFSET_W-1:0]   src_offset,
  output logic                            out_last
);
  import tafs_pkg::*;

  localparam int IDX_W    = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
  localparam int POS_W    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CNT_W    = $clog2(MAX_FRAMES + 1);
  localparam int STP_W    = $clog2(ADVANCE_LIMIT + 1);
  localparam int DEPTH    = MAX_TILES * MAX_FRAMES;
  localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int WALK_MAX = (MAX_TILES < WALK_CAP) ? MAX_TILES : WALK_CAP;
  localparam logic [TIME_W-1:0] TIME_SAT = '1;

  function automatic logic [ADDR_W-1:0] addr_of(input logic [IDX_W-1:0] t,
                                                input logic [POS_W-1:0] p);
    addr_of = ADDR_W'(32'(t) * MAX_FRAMES + 32'(p));
  endfunction

  // Configuration
  logic [ROW_W-1:0] tiles_per_row_r;
  logic [DIM_W-1:0] tile_width_r;
  logic [DIM_W-1:0] tile_height_r;
  logic [PIX_W-1:0] tile_pixels_r;
  logic [ACT_W-1:0] active_tiles_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tiles_per_row_r <= TILES_PER_ROW_RST;
      tile_width_r    <= TILE_WIDTH_RST;
      tile_height_r   <= TILE_HEIGHT_RST;
      tile_pixels_r   <= TILE_PIXELS_RST;
      active_tiles_r  <= ACTIVE_TILES_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_TILES_PER_ROW: tiles_per_row_r <= cfg_wdata[ROW_W-1:0];
        REG_TILE_WIDTH:    tile_width_r    <= cfg_wdata[DIM_W-1:0];
        REG_TILE_HEIGHT:   tile_height_r   <= cfg_wdata[DIM_W-1:0];
        REG_TILE_PIXELS:   tile_pixels_r   <= cfg_wdata[PIX_W-1:0];
        REG_ACTIVE_TILES:  active_tiles_r  <= cfg_wdata[ACT_W-1:0];
        default: ;
      endcase
    end
  end

  // Walk state
  logic [TILE_CNT_W-1:0] tile_r;
  logic [ELAPSED_W-1:0]  elapsed_r;
  logic [TIME_W-1:0]     left_r;
  logic [POS_W-1:0]      pos_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [STP_W-1:0]      steps_r;
  logic                  changed_r;
  logic [TILE_NUM_W-1:0] src_r;

  // Per-tile state
  logic [POS_W-1:0]  fpos_r  [MAX_TILES];
  logic [TIME_W-1:0] tleft_r [MAX_TILES];
  logic [CNT_W-1:0]  fcnt_r  [MAX_TILES];

  // Frame store
  frame_entry_t mem [DEPTH];
  frame_entry_t rd_q_r;
  frame_entry_t wr_entry;

  logic [IDX_W-1:0]      tile_idx;
  logic [IDX_W-1:0]      anim_idx;
  logic                  anim_ok;
  logic                  frame_ok;
  logic [CNT_W-1:0]      total_sat;
  logic [TILE_CNT_W-1:0] walk;
  logic [POS_W-1:0]      cur_pos;
  logic [TIME_W-1:0]     cur_left;
  logic [CNT_W-1:0]      cur_cnt;
  logic [POS_W-1:0]      pos0;
  logic [TIME_W:0]       left_sum;
  logic [TIME_W-1:0]     left0;
  logic [31:0]           pos_inc;
  logic [POS_W-1:0]      pos_next;
  logic                  rd_en;
  logic [ADDR_W-1:0]     raddr;
  logic [ADDR_W-1:0]     waddr;

  always_comb begin
    tile_idx  = IDX_W'(tile_r);
    anim_idx  = IDX_W'(anim_index);
    anim_ok   = (32'(anim_index) < MAX_TILES);
    frame_ok  = (32'(frame_index) < MAX_FRAMES);
    total_sat = (32'(frame_total) > MAX_FRAMES) ? CNT_W'(MAX_FRAMES) : CNT_W'(frame_total);
    walk      = (32'(active_tiles_r) > WALK_MAX) ? TILE_CNT_W'(WALK_MAX)
                                                 : TILE_CNT_W'(active_tiles_r);
    cur_pos   = fpos_r[tile_idx];
    cur_left  = tleft_r[tile_idx];
    cur_cnt   = fcnt_r[tile_idx];
    pos0      = (32'(cur_pos) >= 32'(cur_cnt)) ? '0 : cur_pos;
    left_sum  = {1'b0, cur_left} + (TIME_W + 1)'(elapsed_r);
    left0     = left_sum[TIME_W] ? TIME_SAT : left_sum[TIME_W-1:0];
    pos_inc   = 32'(pos_r) + 32'd1;
    pos_next  = (pos_inc >= 32'(cnt_r)) ? '0 : POS_W'(pos_inc);
    rd_en     = cmd.tile_begin | cmd.advance;
    raddr     = cmd.tile_begin ? addr_of(tile_idx, pos0) : addr_of(tile_idx, pos_next);
    waddr     = addr_of(anim_idx, POS_W'(frame_index));
    wr_entry  = '{dur: frame_time, dst: dst_tile, src: src_tile};
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_entry && anim_ok && frame_ok) begin
      mem[waddr] <= wr_entry;
    end
    if (rd_en) begin
      rd_q_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_TILES; i++) begin
        fpos_r[i]  <= '0;
        tleft_r[i] <= '0;
        fcnt_r[i]  <= '0;
      end
    end else if (cmd.set_count) begin
      if (anim_ok) begin
        fcnt_r[anim_idx]  <= total_sat;
        fpos_r[anim_idx]  <= '0;
        tleft_r[anim_idx] <= '0;
      end
    end else if (cmd.tile_close) begin
      fpos_r[tile_idx]  <= pos_r;
      tleft_r[tile_idx] <= left_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tile_r <= '0;
    end else if (cmd.tick_start) begin
      tile_r <= '0;
    end else if (cmd.next_tile) begin
      tile_r <= tile_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tick_start) begin
      elapsed_r <= elapsed;
    end
    if (cmd.tile_begin) begin
      pos_r     <= pos0;
      left_r    <= left0;
      cnt_r     <= cur_cnt;
      steps_r   <= '0;
      changed_r <= 1'b0;
    end else if (cmd.advance) begin
      pos_r     <= pos_next;
      left_r    <= left_r - TIME_W'(rd_q_r.dur);
      steps_r   <= steps_r + 1'b1;
      changed_r <= 1'b1;
    end
    if (cmd.tile_close) begin
      src_r <= rd_q_r.src;
    end
  end

  // Slot row and column
  logic [ROW_W-1:0]      row_eff;
  logic                  div_busy;
  logic [TILE_NUM_W-1:0] div_quot;
  logic [TILE_NUM_W-1:0] div_rem;

  assign row_eff = (tiles_per_row_r == '0) ? ROW_W'(1) : tiles_per_row_r;

  tafs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (rd_q_r.dst),
    .divisor  (row_eff),
    .busy     (div_busy),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // Products, then pending result, then output register
  logic [TILE_NUM_W+DIM_W-1:0] dx_full;
  logic [TILE_NUM_W+DIM_W-1:0] dy_full;
  logic [TILE_NUM_W+PIX_W-1:0] so_full;
  logic [COORD_W-1:0]          dx_r;
  logic [COORD_W-1:0]          dy_r;
  logic [OFFSET_W-1:0]         so_r;
  logic                        pend_v_r;
  logic [OUT_TILE_W-1:0]       pend_tile_r;
  logic [COORD_W-1:0]          pend_dx_r;
  logic [COORD_W-1:0]          pend_dy_r;
  logic [OFFSET_W-1:0]         pend_so_r;
  logic                        out_valid_r;
  logic [OUT_TILE_W-1:0]       out_tile_r;
  logic [COORD_W-1:0]          out_dx_r;
  logic [COORD_W-1:0]          out_dy_r;
  logic [OFFSET_W-1:0]         out_so_r;
  logic                        out_last_r;

  assign dx_full = div_rem * tile_width_r;
  assign dy_full = div_quot * tile_height_r;
  assign so_full = src_r * tile_pixels_r;

  always_ff @(posedge clk) begin
    if (cmd.mul_cap) begin
      dx_r <= dx_full[COORD_W-1:0];
      dy_r <= dy_full[COORD_W-1:0];
      so_r <= so_full[OFFSET_W-1:0];
    end
    if (cmd.pend_load) begin
      pend_tile_r <= OUT_TILE_W'(tile_r);
      pend_dx_r   <= dx_r;
      pend_dy_r   <= dy_r;
      pend_so_r   <= so_r;
    end
    if (cmd.out_push) begin
      out_tile_r <= pend_tile_r;
      out_dx_r   <= pend_dx_r;
      out_dy_r   <= pend_dy_r;
      out_so_r   <= pend_so_r;
      out_last_r <= cmd.out_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.pend_load) begin
        pend_v_r <= 1'b1;
      end else if (cmd.out_push || cmd.tick_start) begin
        pend_v_r <= 1'b0;
      end
      if (cmd.out_push) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    status.tile_end   = (tile_r >= walk);
    status.cnt_zero   = (cur_cnt == '0);
    status.can_adv    = (32'(steps_r) < ADVANCE_LIMIT) && (left_r >= TIME_W'(rd_q_r.dur));
    status.changed    = changed_r;
    status.div_busy   = div_busy;
    status.pend_valid = pend_v_r;
    status.out_free   = !out_valid_r || out_ready;
  end

  assign out_valid  = out_valid_r;
  assign out_tile   = out_tile_r;
  assign dest_x     = out_dx_r;
  assign dest_y     = out_dy_r;
  assign src_offset = out_so_r;
  assign out_last   = out_last_r;

endmodule

>>> src/tafs_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences load items and the per-tick walk over animated tiles.
// Depends on tafs_pkg; drives the datapath through cmd_t, reads status_t.
module tafs_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [tafs_pkg::FUNC_W-1:0] in_func,
  output logic                        in_ready,
  input  tafs_pkg::status_t           status,
  output tafs_pkg::cmd_t              cmd
);
  import tafs_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = (state_r == ST_IDLE);
    accept    = in_valid && in_ready;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (func_t'(in_func))
            FUNC_WRITE: cmd.wr_entry = 1'b1;
            FUNC_COUNT: cmd.set_count = 1'b1;
            FUNC_TICK: begin
              cmd.tick_start = 1'b1;
              state_nxt      = ST_LOAD;
            end
            FUNC_NONE: ;
          endcase
        end
      end
      ST_LOAD: begin
        priority if (status.tile_end) begin
          state_nxt = status.pend_valid ? ST_FLUSH : ST_IDLE;
        end else if (status.cnt_zero) begin
          cmd.next_tile = 1'b1;
        end else begin
          cmd.tile_begin = 1'b1;
          state_nxt      = ST_CMP;
        end
      end
      ST_CMP: begin
        if (status.can_adv) begin
          cmd.advance = 1'b1;
        end else begin
          cmd.tile_close = 1'b1;
          if (status.changed) begin
            cmd.div_start = 1'b1;
            state_nxt     = ST_DIV;
          end else begin
            cmd.next_tile = 1'b1;
            state_nxt     = ST_LOAD;
          end
        end
      end
      ST_DIV: begin
        if (!status.div_busy) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul_cap = 1'b1;
        state_nxt   = ST_EMIT;
      end
      ST_EMIT: begin
        // Release the older command only now that a later one exists
        priority if (!status.pend_valid) begin
          cmd.pend_load = 1'b1;
          cmd.next_tile = 1'b1;
          state_nxt     = ST_LOAD;
        end else if (status.out_free) begin
          cmd.out_push  = 1'b1;
          cmd.pend_load = 1'b1;
          cmd.next_tile = 1'b1;
          state_nxt     = ST_LOAD;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_FLUSH: begin
        if (status.out_free) begin
          cmd.out_push = 1'b1;
          cmd.out_last = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

>>> src/tile_animation_frame_stepper_top.sv
`timescale 1ns / 1ps
// Tile animation frame stepper. Load items (write a frame entry, set a tile's
// frame count) are handled in the idle state. A tick walks the active tiles one
// at a time: a tile without frames is skipped, and a tile with frames is read and
// then advanced frame by frame, each advance reading the frame store once; a
// tile whose frame changed also passes through the slot divider, the product
// stage and the hand-off of its copy command, and the final command of the tick
// is flushed at the end of the walk. A tick walks at most 16 active tiles and
// makes at most ADVANCE_LIMIT frame advances per tile. Commands leave through
// an output register, so the next item is taken while the last one waits.
module tile_animation_frame_stepper_top #(
  parameter int MAX_TILES     = tafs_pkg::MAX_TILES_DEF,
  parameter int MAX_FRAMES    = tafs_pkg::MAX_FRAMES_DEF,
  parameter int ADVANCE_LIMIT = tafs_pkg::ADVANCE_LIMIT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // anim_index[3:0], frame_index[7:4], src_tile[19:8], dst_tile[31:20],
  // frame_time[47:32], frame_total[52:48], elapsed[68:53], zero[71:69]
  input  logic [tafs_pkg::IN_DATA_W-1:0]  in_tdata,
  // func[1:0]
  input  logic [tafs_pkg::FUNC_W-1:0]     in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // out_tile[3:0], dest_x[23:4], dest_y[43:24], src_offset[71:44]
  output logic [tafs_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                            out_tlast,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tafs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tafs_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tafs_pkg::*;

  cmd_t                  cmd;
  status_t               status;
  logic [OUT_TILE_W-1:0] out_tile;
  logic [COORD_W-1:0]    dest_x;
  logic [COORD_W-1:0]    dest_y;
  logic [OFFSET_W-1:0]   src_offset;

  assign cfg_ready = 1'b1;

  tafs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_func  (in_tuser),
    .in_ready (in_tready),
    .status   (status),
    .cmd      (cmd)
  );

  tafs_datapath #(
    .MAX_TILES     (MAX_TILES),
    .MAX_FRAMES    (MAX_FRAMES),
    .ADVANCE_LIMIT (ADVANCE_LIMIT)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr      (cfg_valid),
    .cfg_idx     (cfg_index),
    .cfg_wdata   (cfg_data),
    .anim_index  (in_tdata[3:0]),
    .frame_index (in_tdata[7:4]),
    .src_tile    (in_tdata[19:8]),
    .dst_tile    (in_tdata[31:20]),
    .frame_time  (in_tdata[47:32]),
    .frame_total (in_tdata[52:48]),
    .elapsed     (in_tdata[68:53]),
    .cmd         (cmd),
    .status      (status),
    .out_ready   (out_tready),
    .out_valid   (out_tvalid),
    .out_tile    (out_tile),
    .dest_x      (dest_x),
    .dest_y      (dest_y),
    .src_offset  (src_offset),
    .out_last    (out_tlast)
  );

  assign out_tdata = {src_offset, dest_y, dest_x, out_tile};

endmodule

>>> src/tafs_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the tile animation frame stepper, bound to the top.
// Depends on tafs_pkg for the function codes.
module tafs_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [tafs_pkg::FUNC_W-1:0]     in_tuser,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [tafs_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                            out_tlast
);
  import tafs_pkg::*;

  // A stalled result transaction holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output changed while stalled");

  // A tick occupies the block for at least the following cycle
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == FUNC_TICK |=> !in_tready)
    else $error("input ready right after a tick");

  // Load items and unused codes leave the input ready again in the following cycle
  a_load_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready &&
    (in_tuser == FUNC_WRITE || in_tuser == FUNC_COUNT || in_tuser == FUNC_NONE)
    |=> in_tready)
    else $error("input not ready after a load item");

  // Reset leaves the block idle with nothing to deliver
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("block not idle after reset");

endmodule

bind tile_animation_frame_stepper_top tafs_checker u_tafs_checker (.*);

>>> tb/sv/tafs_command_checker.sv
`timescale 1ns / 1ps
// Copy-command checker for the tile animation frame stepper: watches the load,
// tick, config and command channels, predicts commands and compares them in order.
// Depends on tafs_pkg for widths, register indexes and function codes.
module tafs_command_checker
  import tafs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [FUNC_W-1:0]     in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  out_tlast,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    cmds_pending,
  output int                    cmds_checked,
  output int                    errors
);

  localparam int REPORT_CAP = 40;
  localparam int STORE_DEPTH = MAX_TILES_DEF * MAX_FRAMES_DEF;

  typedef struct packed {
    logic [OUT_TILE_W-1:0] tile;
    logic [COORD_W-1:0]    dest_x;
    logic [COORD_W-1:0]    dest_y;
    logic [OFFSET_W-1:0]   src_offset;
    logic                  last;
  } copy_cmd_t;

  copy_cmd_t copy_q[$];

  // Shadow of the block's configuration and per-tile animation state
  logic [ROW_W-1:0]      row_tiles;
  logic [DIM_W-1:0]      tile_w;
  logic [DIM_W-1:0]      tile_h;
  logic [PIX_W-1:0]      tile_pix;
  logic [ACT_W-1:0]      walk_tiles;
  logic [TILE_NUM_W-1:0] ent_src [STORE_DEPTH];
  logic [TILE_NUM_W-1:0] ent_dst [STORE_DEPTH];
  logic [DUR_W-1:0]      ent_dur [STORE_DEPTH];
  logic [INDEX_W-1:0]    cur_frame [MAX_TILES_DEF];
  logic [TIME_W-1:0]     leftover [MAX_TILES_DEF];
  logic [TOTAL_W-1:0]    n_frames [MAX_TILES_DEF];

  // Step every walked tile by the elapsed time and queue one command per changed tile
  task automatic advance_tiles(input logic [ELAPSED_W-1:0] dt);
    int walk, steps, base, e, queued;
    logic [ROW_W-1:0] row;
    logic [INDEX_W-1:0] pos;
    logic [TIME_W:0] sum;
    logic [TIME_W-1:0] left;
    logic [31:0] d32, r32, col, rw, prod;
    bit moved;
    copy_cmd_t c;
    walk = walk_tiles;
    if (walk > MAX_TILES_DEF) walk = MAX_TILES_DEF;
    if (walk > WALK_CAP) walk = WALK_CAP;
    row = (row_tiles == 0) ? ROW_W'(1) : row_tiles;
    queued = 0;
    for (int t = 0; t < walk; t++) begin
      if (n_frames[t] == 0) continue;
      base = t * MAX_FRAMES_DEF;
      pos = cur_frame[t];
      if (pos >= n_frames[t]) pos = '0;
      sum = {1'b0, leftover[t]} + dt;
      left = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
      steps = 0;
      moved = 1'b0;
      while (steps < ADVANCE_LIMIT_DEF && left >= ent_dur[base + pos]) begin
        left = left - ent_dur[base + pos];
        pos = (int'(pos) + 1 >= int'(n_frames[t])) ? '0 : pos + 1'b1;
        steps++;
        moved = 1'b1;
      end
      leftover[t] = left;
      cur_frame[t] = pos;
      if (moved) begin
        e = base + pos;
        d32 = ent_dst[e];
        r32 = row;
        col = d32 % r32;
        rw = d32 / r32;
        c.tile = t[OUT_TILE_W-1:0];
        prod = col * tile_w;
        c.dest_x = prod[COORD_W-1:0];
        prod = rw * tile_h;
        c.dest_y = prod[COORD_W-1:0];
        prod = ent_src[e] * tile_pix;
        c.src_offset = prod[OFFSET_W-1:0];
        c.last = 1'b0;
        copy_q.push_back(c);
        queued++;
      end
    end
    // mark the final command of this tick
    if (queued > 0) begin
      c = copy_q.pop_back();
      c.last = 1'b1;
      copy_q.push_back(c);
    end
  endtask

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= REPORT_CAP)
        $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    logic [INDEX_W-1:0] a, fi;
    logic [TOTAL_W-1:0] tot;
    copy_cmd_t want;
    if (!rst_n) begin
      row_tiles = TILES_PER_ROW_RST;
      tile_w = TILE_WIDTH_RST;
      tile_h = TILE_HEIGHT_RST;
      tile_pix = TILE_PIXELS_RST;
      walk_tiles = ACTIVE_TILES_RST;
      for (int i = 0; i < MAX_TILES_DEF; i++) begin
        cur_frame[i] = '0;
        leftover[i] = '0;
        n_frames[i] = '0;
      end
      copy_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TILES_PER_ROW: row_tiles = cfg_data[ROW_W-1:0];
          REG_TILE_WIDTH:    tile_w = cfg_data[DIM_W-1:0];
          REG_TILE_HEIGHT:   tile_h = cfg_data[DIM_W-1:0];
          REG_TILE_PIXELS:   tile_pix = cfg_data[PIX_W-1:0];
          REG_ACTIVE_TILES:  walk_tiles = cfg_data[ACT_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        a = in_tdata[3:0];
        fi = in_tdata[7:4];
        case (func_t'(in_tuser))
          FUNC_WRITE: begin
            ent_src[a * MAX_FRAMES_DEF + fi] = in_tdata[19:8];
            ent_dst[a * MAX_FRAMES_DEF + fi] = in_tdata[31:20];
            ent_dur[a * MAX_FRAMES_DEF + fi] = in_tdata[47:32];
          end
          FUNC_COUNT: begin
            tot = in_tdata[52:48];
            n_frames[a] = (tot > MAX_FRAMES_DEF) ? MAX_FRAMES_DEF : tot;
            cur_frame[a] = '0;
            leftover[a] = '0;
          end
          FUNC_TICK: advance_tiles(in_tdata[68:53]);
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (copy_q.size() == 0) begin
          errors++;
          $display("%0t: copy command with none expected, actual tile %0d data 0x%0h",
                   $time, out_tdata[3:0], out_tdata);
        end else begin
          want = copy_q.pop_front();
          cmds_checked++;
          check_field("out_tile", want.tile, out_tdata[3:0]);
          check_field("dest_x", want.dest_x, out_tdata[23:4]);
          check_field("dest_y", want.dest_y, out_tdata[43:24]);
          check_field("src_offset", want.src_offset, out_tdata[71:44]);
          check_field("tlast", want.last, out_tlast);
        end
      end
    end
    cmds_pending <= copy_q.size();
  end

endmodule

>>> tb/sv/tb_tile_animation_frame_stepper_top.sv
`timescale 1ns / 1ps
// Testbench top for the tile animation frame stepper: clock, reset, load, tick
// and config stimulus, output back-pressure, watchdog and verdict.
// Depends on tafs_pkg, the stepper RTL and tafs_command_checker.
module tb_tile_animation_frame_stepper_top;
  import tafs_pkg::*;

  localparam int HOLD_OFF = 3000;
  localparam int SETTLE_CYCLES = 1500;
  localparam int STALL_LIMIT = 20000;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [FUNC_W-1:0]     in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int cmds_pending, cmds_checked, errors;

  logic steady = 1'b0;
  logic squeeze = 1'b0;
  logic squeeze_done = 1'b0;
  int   stall_cycles = 0;
  int   walk_now = 0;
  int   n_items = 0, n_ticks = 0, n_loads = 0, n_noise = 0, n_cfg = 0, n_settings = 0;
  bit   written [MAX_TILES_DEF][MAX_FRAMES_DEF];

  tile_animation_frame_stepper_top dut (.*);

  tafs_command_checker cmd_check (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Receiver: random back-pressure, a steady stretch, and one long hold-off
  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (squeeze && !squeeze_done) begin
        out_tready <= 1'b0;
        repeat (HOLD_OFF) @(posedge clk);
        squeeze_done <= 1'b1;
      end else begin
        out_tready <= steady ? 1'b1 : ($urandom_range(99) >= 38);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: watchdog, no transaction for %0d cycles", $time, stall_cycles);
        $display("tb_tile_animation_frame_stepper_top: errors");
        $finish;
      end
    end
  end

  function automatic logic [IN_DATA_W-1:0] random_bits();
    logic [IN_DATA_W-1:0] d;
    d = {$urandom, $urandom, $urandom};
    d[IN_DATA_W-1:69] = '0;
    return d;
  endfunction

  function automatic logic [DUR_W-1:0] pick_dur();
    int r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 18) return '1;
    if (r < 30) return $urandom_range(65535);
    return $urandom_range(1, 60);
  endfunction

  function automatic logic [ELAPSED_W-1:0] pick_elapsed();
    int r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 18) return '1;
    if (r < 30) return $urandom_range(65535);
    return $urandom_range(0, 120);
  endfunction

  // Offer one transaction, with random idle cycles ahead of it; leave tvalid high
  task automatic send(input func_t f, input logic [IN_DATA_W-1:0] d);
    while (!steady && $urandom_range(99) < 38) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= f;
    in_tdata <= d;
    do @(posedge clk); while (!in_tready);
    if (f == FUNC_NONE) n_noise++;
    else n_items++;
  endtask

  task automatic write_entry(input int a, input int f, input logic [TILE_NUM_W-1:0] src,
                             input logic [TILE_NUM_W-1:0] dst, input logic [DUR_W-1:0] dur);
    logic [IN_DATA_W-1:0] d;
    d = random_bits();
    d[3:0] = a;
    d[7:4] = f;
    d[19:8] = src;
    d[31:20] = dst;
    d[47:32] = dur;
    send(FUNC_WRITE, d);
    written[a][f] = 1'b1;
    n_loads++;
  endtask

  // Fill any unwritten entry below the new count so a tick never reads stale data
  task automatic set_frames(input int a, input int total);
    logic [IN_DATA_W-1:0] d;
    int n;
    n = (total > MAX_FRAMES_DEF) ? MAX_FRAMES_DEF : total;
    for (int f = 0; f < n; f++)
      if (!written[a][f])
        write_entry(a, f, $urandom_range(4095), $urandom_range(4095), pick_dur());
    d = random_bits();
    d[3:0] = a;
    d[52:48] = total;
    send(FUNC_COUNT, d);
    n_loads++;
  endtask

  task automatic tick(input logic [ELAPSED_W-1:0] el);
    logic [IN_DATA_W-1:0] d;
    d = random_bits();
    d[68:53] = el;
    send(FUNC_TICK, d);
    n_ticks++;
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    n_cfg++;
  endtask

  task automatic set_config(input int row, input int w, input int h, input int pix,
                            input int act, input bit spare);
    set_reg(REG_TILES_PER_ROW, row);
    set_reg(REG_TILE_WIDTH, w);
    set_reg(REG_TILE_HEIGHT, h);
    set_reg(REG_TILE_PIXELS, pix);
    set_reg(REG_ACTIVE_TILES, act);
    if (spare) set_reg(REG_SPARE, $urandom_range(131071));
    cfg_valid <= 1'b0;
    walk_now = (act > WALK_CAP) ? WALK_CAP : act;
    n_settings++;
  endtask

  // Drop tvalid, wait out every expected command, then let a no-result tick finish
  task automatic quiesce();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (cmds_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_random(input int target, input bit hog);
    int stop, a, n, r;
    stop = n_items + target;
    // zero-duration frame on tile 0 to hit the advance cap and saturate leftover time
    if (hog) begin
      write_entry(0, 0, $urandom_range(4095), $urandom_range(4095), '0);
      set_frames(0, 1);
      repeat (18) tick('1);
    end
    while (n_items < stop) begin
      r = $urandom_range(99);
      if (r < 55) begin
        a = (walk_now == 0) ? $urandom_range(15) : $urandom_range(walk_now - 1);
        r = $urandom_range(99);
        n = (r < 70) ? $urandom_range(1, 4) : (r < 90) ? $urandom_range(5, 8) : MAX_FRAMES_DEF;
        for (int f = 0; f < n; f++)
          write_entry(a, f, $urandom_range(4095), $urandom_range(4095), pick_dur());
        set_frames(a, (n == MAX_FRAMES_DEF) ? $urandom_range(16, 31) : n);
        repeat ($urandom_range(1, 4)) tick(pick_elapsed());
      end else if (r < 80) begin
        tick(pick_elapsed());
      end else begin
        case ($urandom_range(2))
          0: send(FUNC_NONE, random_bits());
          1: write_entry($urandom_range(15), $urandom_range(15), $urandom_range(4095),
                         $urandom_range(4095), pick_dur());
          default: set_frames($urandom_range(15), $urandom_range(31));
        endcase
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset settings, then zero row width, widest products, too many tiles
    tick('0);
    quiesce();
    set_config(0, 511, 511, 131071, 31, 1'b0);
    tick('0);
    write_entry(0, 0, 12'hFFF, 12'hFFF, '0);
    write_entry(0, 1, 12'h000, 12'h000, '1);
    set_frames(0, 2);
    tick('0);
    tick('1);
    write_entry(1, 0, 12'hAAA, 12'h555, '0);
    set_frames(1, 1);
    tick('1);
    send(FUNC_NONE, {3'b000, {69{1'b1}}});
    set_frames(15, 31);
    tick(16'd40000);
    set_frames(0, 0);
    tick(16'd1);
    set_frames(1, 1);
    tick('1);
    quiesce();

    // Sheet-like settings, no idling on either side
    set_config($urandom_range(1, 64), 16, 16, 256, 16, 1'b0);
    steady <= 1'b1;
    run_random(75, 1'b1);
    steady <= 1'b0;
    quiesce();

    // Unit sizes; hold the receiver off while ticks keep coming
    set_config(1, 1, 1, 1, $urandom_range(1, 16), 1'b0);
    run_random(60, 1'b0);
    squeeze <= 1'b1;
    repeat (40) tick(pick_elapsed());
    quiesce();

    set_config($urandom_range(8191), $urandom_range(511), $urandom_range(511),
               $urandom_range(131071), $urandom_range(31), 1'b0);
    run_random(70, 1'b0);
    quiesce();

    set_config(8191, 511, 511, 131071, 16, 1'b1);
    run_random(70, 1'b1);
    quiesce();

    set_config($urandom_range(1, 8191), 0, 0, 0, $urandom_range(17, 31), 1'b0);
    run_random(70, 1'b0);
    quiesce();

    $display("covered %0d items (%0d ticks, %0d loads) plus %0d unused-code items",
             n_items, n_ticks, n_loads, n_noise);
    $display("%0d register writes over %0d settings, %0d copy commands compared",
             n_cfg, n_settings, cmds_checked);
    if (errors == 0 && cmds_pending == 0)
      $display("tb_tile_animation_frame_stepper_top: clean");
    else
      $display("tb_tile_animation_frame_stepper_top: errors");
    $finish;
  end

endmodule
